@@ hw/rtl/bbx_pkg.sv @@
package bbx_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int SAMPLE_W     = 16;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
  localparam int OUT_ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W      = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W     = $clog2(MAX_HEIGHT + 1);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd768;

  // register index, taken from paddr[ADDR_W-1]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // divide by nine: floor(s * 932068 / 2^23) is exact for s below 2^21
  localparam int SUM_W      = $clog2(9 * (2 ** SAMPLE_W));
  localparam int MUL_W      = 20;
  localparam int PROD_W     = SUM_W + MUL_W;
  localparam int DIV9_SHIFT = 23;
  localparam logic [MUL_W-1:0] DIV9_MUL = 20'd932068;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;
    logic                frame_last;
  } blur_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic                restart;
  } frame_cfg_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic             pix_ok;
    logic [COL_W-1:0] column;
  } step_t;

  // one line buffer entry: samples one and two rows back
  typedef struct packed {
    rgb_t near;
    rgb_t far;
  } entry_t;

  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } column_t;

endpackage

@@ hw/rtl/bbx_cfg.sv @@
module bbx_cfg import bbx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output frame_cfg_t        frame_cfg
);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic                    wr_en;
  logic                    reg_sel;

  assign reg_sel = paddr[ADDR_W-1];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH: begin
          image_width <= pwdata[WIDTH_REG_W-1:0];
        end
        REG_HEIGHT: begin
          image_height <= pwdata[HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH: begin
        prdata = DATA_W'(image_width);
      end
      default: begin
        prdata = DATA_W'(image_height);
      end
    endcase
  end

  // clamp to the supported frame size
  always_comb begin
    frame_cfg.width = WIDTH_W'(image_width);
    if (image_width == '0) begin
      frame_cfg.width = WIDTH_W'(1);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      frame_cfg.width = WIDTH_W'(MAX_WIDTH);
    end
    frame_cfg.height = HEIGHT_W'(image_height);
    if (image_height == '0) begin
      frame_cfg.height = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      frame_cfg.height = HEIGHT_W'(MAX_HEIGHT);
    end
    frame_cfg.restart = wr_en;
  end

endmodule

@@ hw/rtl/bbx_ctrl.sv @@
module bbx_ctrl import bbx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_cfg_t frame_cfg,
  input  logic       accept,
  input  logic       kind,
  output step_t      step
);

  logic [COL_W-1:0]     in_column;
  logic [ROW_W-1:0]     in_row;
  logic [COL_W-1:0]     out_column;
  logic [OUT_ROW_W-1:0] out_row;

  logic [COL_W-1:0]    w_last;
  logic [HEIGHT_W-1:0] h_last;
  logic                in_col_end;
  logic                out_col_end;
  logic                out_row_end;
  logic                priming;

  assign w_last      = COL_W'(frame_cfg.width - WIDTH_W'(1));
  assign h_last      = frame_cfg.height - HEIGHT_W'(1);
  assign in_col_end  = (in_column == w_last);
  assign out_col_end = (out_column == w_last);
  assign out_row_end = (HEIGHT_W'(out_row) == h_last);

  // the first width+1 beats only fill the window
  assign priming = (in_row == '0) || ((in_row == ROW_W'(1)) && (in_column == '0));

  always_comb begin
    step.tag.emit     = !priming;
    step.tag.last     = out_row_end && out_col_end;
    step.tag.top_ok   = (out_row != '0);
    step.tag.bot_ok   = !out_row_end;
    step.tag.left_ok  = (out_column != '0);
    step.tag.right_ok = !out_col_end;
    step.pix_ok       = !kind && (in_row < ROW_W'(frame_cfg.height));
    step.column       = in_column;
  end

  always_ff @(posedge clk) begin
    if (rst || frame_cfg.restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      if (step.tag.emit && step.tag.last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        in_column <= in_col_end ? '0 : in_column + 1'b1;
        if (in_col_end) begin
          in_row <= in_row + 1'b1;
        end
        if (step.tag.emit) begin
          out_column <= out_col_end ? '0 : out_column + 1'b1;
          if (out_col_end) begin
            out_row <= out_row + 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/bbx_line.sv @@
module bbx_line import bbx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  pixel_t  pixel,
  input  step_t   step,
  output logic    ready,
  output logic    col_valid,
  output column_t col,
  output tag_t    col_tag,
  input  logic    col_ready
);

  entry_t mem [MAX_WIDTH];

  entry_t           rd_entry;
  entry_t           wr_entry;
  rgb_t             s1_pix;
  logic [COL_W-1:0] s1_column;
  tag_t             s1_tag;
  logic             s1_valid;
  logic             advance;
  logic             bypass;

  assign advance  = s1_valid && col_ready;
  assign ready    = !s1_valid || col_ready;
  assign wr_entry = {s1_pix, rd_entry.near};
  // width of one: the entry being written is the one read next
  assign bypass   = advance && (s1_column == step.column);

  always_ff @(posedge clk) begin
    if (advance) begin
      mem[s1_column] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry <= bypass ? wr_entry : mem[step.column];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= step.pix_ok ? {pixel.red_in, pixel.green_in, pixel.blue_in} : '0;
      s1_column <= step.column;
      s1_tag    <= step.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= accept;
    end
  end

  assign col_valid = s1_valid;
  assign col       = {rd_entry.far, rd_entry.near, s1_pix};
  assign col_tag   = s1_tag;

endmodule

@@ hw/rtl/bbx_win.sv @@
module bbx_win import bbx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          col_valid,
  input  column_t       col,
  input  tag_t          col_tag,
  output logic          col_ready,
  output logic          win_valid,
  output column_t [2:0] window,
  output tag_t          win_tag,
  input  logic          win_ready
);

  logic shift;

  assign col_ready = !win_valid || win_ready;
  assign shift     = col_valid && col_ready;

  // window[0] is the newest column, window[2] the oldest
  always_ff @(posedge clk) begin
    if (shift) begin
      window  <= {window[1:0], col};
      win_tag <= col_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (col_ready) begin
      win_valid <= shift && col_tag.emit;
    end
  end

endmodule

@@ hw/rtl/bbx_mean.sv @@
module bbx_mean import bbx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          win_valid,
  input  column_t [2:0] window,
  input  tag_t          win_tag,
  output logic          win_ready,
  output logic          blur_valid,
  output blur_t         blur,
  input  logic          blur_stall
);

  logic [2:0]        col_on;
  logic [SUM_W-1:0]  acc_red;
  logic [SUM_W-1:0]  acc_green;
  logic [SUM_W-1:0]  acc_blue;
  logic [SUM_W-1:0]  sum_red;
  logic [SUM_W-1:0]  sum_green;
  logic [SUM_W-1:0]  sum_blue;
  logic              sum_last;
  logic              sum_valid;
  logic              out_ready;
  logic [PROD_W-1:0] prod_red;
  logic [PROD_W-1:0] prod_green;
  logic [PROD_W-1:0] prod_blue;

  assign col_on = {win_tag.left_ok, 1'b1, win_tag.right_ok};

  // neighbors outside the frame add zero
  always_comb begin
    acc_red   = '0;
    acc_green = '0;
    acc_blue  = '0;
    for (int k = 0; k < 3; k++) begin
      if (col_on[k] && win_tag.top_ok) begin
        acc_red   = acc_red   + SUM_W'(window[k].top.red);
        acc_green = acc_green + SUM_W'(window[k].top.green);
        acc_blue  = acc_blue  + SUM_W'(window[k].top.blue);
      end
      if (col_on[k]) begin
        acc_red   = acc_red   + SUM_W'(window[k].mid.red);
        acc_green = acc_green + SUM_W'(window[k].mid.green);
        acc_blue  = acc_blue  + SUM_W'(window[k].mid.blue);
      end
      if (col_on[k] && win_tag.bot_ok) begin
        acc_red   = acc_red   + SUM_W'(window[k].bot.red);
        acc_green = acc_green + SUM_W'(window[k].bot.green);
        acc_blue  = acc_blue  + SUM_W'(window[k].bot.blue);
      end
    end
  end

  assign out_ready = !blur_valid || !blur_stall;
  assign win_ready = !sum_valid || out_ready;

  always_ff @(posedge clk) begin
    if (win_valid && win_ready) begin
      sum_red   <= acc_red;
      sum_green <= acc_green;
      sum_blue  <= acc_blue;
      sum_last  <= win_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (win_ready) begin
      sum_valid <= win_valid;
    end
  end

  assign prod_red   = PROD_W'(sum_red)   * PROD_W'(DIV9_MUL);
  assign prod_green = PROD_W'(sum_green) * PROD_W'(DIV9_MUL);
  assign prod_blue  = PROD_W'(sum_blue)  * PROD_W'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (sum_valid && out_ready) begin
      blur.red_out    <= prod_red[DIV9_SHIFT +: SAMPLE_W];
      blur.green_out  <= prod_green[DIV9_SHIFT +: SAMPLE_W];
      blur.blue_out   <= prod_blue[DIV9_SHIFT +: SAMPLE_W];
      blur.frame_last <= sum_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_valid <= 1'b0;
    end else if (out_ready) begin
      blur_valid <= sum_valid;
    end
  end

endmodule

@@ hw/rtl/rgb_box_blur_3x3.sv @@
// channel   direction  handshake                 payload
// pixel     in         pixel_valid, pixel_stall  pixel_t (kind, red/green/blue_in)
// blur      out        blur_valid, blur_stall    blur_t (red/green/blue_out, frame_last)
// config    in         apb write/read            image_width at 0, image_height at 4
//
// one pixel beat per cycle, sustained while blur_stall is low; a taken beat reaches the result
// register through the line buffer read on the taking edge, then the window, sum
// and multiply stages
// the result for a pixel leaves with the beat width+1 positions later in the stream
// rst clears the control state and loads 1024x768; line buffers need no clearing
// each stage holds while the one after it is full, so a blur stall reaches
// pixel_stall only once every stage is occupied
module rgb_box_blur_3x3 import bbx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  pixel_t            pixel,
  output logic              blur_valid,
  input  logic              blur_stall,
  output blur_t             blur
);

  frame_cfg_t    frame_cfg;
  step_t         step;
  logic          accept;
  logic          line_ready;
  logic          col_valid;
  column_t       col;
  tag_t          col_tag;
  logic          col_ready;
  logic          win_valid;
  column_t [2:0] window;
  tag_t          win_tag;
  logic          win_ready;

  assign pixel_stall = !line_ready;
  assign accept      = pixel_valid && line_ready;

  bbx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .frame_cfg (frame_cfg)
  );

  bbx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .frame_cfg (frame_cfg),
    .accept    (accept),
    .kind      (pixel.kind),
    .step      (step)
  );

  bbx_line u_line (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (pixel),
    .step      (step),
    .ready     (line_ready),
    .col_valid (col_valid),
    .col       (col),
    .col_tag   (col_tag),
    .col_ready (col_ready)
  );

  bbx_win u_win (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col       (col),
    .col_tag   (col_tag),
    .col_ready (col_ready),
    .win_valid (win_valid),
    .window    (window),
    .win_tag   (win_tag),
    .win_ready (win_ready)
  );

  bbx_mean u_mean (
    .clk        (clk),
    .rst        (rst),
    .win_valid  (win_valid),
    .window     (window),
    .win_tag    (win_tag),
    .win_ready  (win_ready),
    .blur_valid (blur_valid),
    .blur       (blur),
    .blur_stall (blur_stall)
  );

endmodule

@@ hw/rtl/bbx_check.sv @@
module bbx_check import bbx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pixel_stall,
  input logic              blur_valid,
  input logic              blur_stall,
  input blur_t             blur
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !blur_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    blur_valid && blur_stall |=> blur_valid && $stable(blur))
    else $error("stalled result beat changed");

  // a free result slot lets every stage move, so input is never held
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!blur_valid || !blur_stall) |-> !pixel_stall)
    else $error("input stalled while the result side is free");

  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[ADDR_W-1] == REG_WIDTH) |=>
    (paddr[ADDR_W-1] != REG_WIDTH ||
     prdata[WIDTH_REG_W-1:0] == $past(pwdata[WIDTH_REG_W-1:0])))
    else $error("width register readback mismatch");

endmodule

bind rgb_box_blur_3x3 bbx_check u_check (.*);
